[rtl/core/multi_list_block_link_manager_assert.svh]
// Assertion macros used by the checker file.
`ifndef MULTI_LIST_BLOCK_LINK_MANAGER_ASSERT_SVH
`define MULTI_LIST_BLOCK_LINK_MANAGER_ASSERT_SVH

// Same-cycle implication, idle while reset is high.
`define LBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is high.
`define LBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs during reset.
`define LBM_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lbm_pkg.sv]
package lbm_pkg;

  // Sizing
  localparam int NUM_BLOCKS  = 1024;
  localparam int NUM_LISTS   = 64;
  localparam int BLK_AW      = $clog2(NUM_BLOCKS);
  localparam int LINK_W      = $clog2(NUM_BLOCKS + 1);
  localparam int LIST_AW     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  // Beat field widths
  localparam int LIST_IDX_W  = 6;
  localparam int BLOCK_IDX_W = 10;
  localparam int FIELD_W     = 11;

  // Link value that marks a missing block
  localparam logic [LINK_W-1:0] NONE = LINK_W'(NUM_BLOCKS);

  // Operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  // Per-list record: head, tail and count
  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] count;
  } list_rec_t;

  localparam list_rec_t REC_RESET = '{head: NONE, tail: NONE, count: '0};

  // One pending link table write
  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } seq_state_t;

endpackage

[rtl/core/lbm_req_if.sv]
interface lbm_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [lbm_pkg::LIST_IDX_W-1:0]    list_index;
  logic [lbm_pkg::BLOCK_IDX_W-1:0]   block_index;

  modport source (output valid, opcode, list_index, block_index, input ready);
  modport sink   (input valid, opcode, list_index, block_index, output ready);
endinterface

[rtl/core/lbm_rsp_if.sv]
interface lbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [lbm_pkg::FIELD_W-1:0]   head_block;
  logic [lbm_pkg::FIELD_W-1:0]   tail_block;
  logic [lbm_pkg::FIELD_W-1:0]   block_count;

  modport source (output valid, status, head_block, tail_block, block_count, input ready);
  modport sink   (input valid, status, head_block, tail_block, block_count, output ready);
endinterface

[rtl/core/lbm_link_ram.sv]
module lbm_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/lbm_list_store.sv]
module lbm_list_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [lbm_pkg::LIST_AW-1:0] rd_addr,
  output lbm_pkg::list_rec_t        rd_rec,
  input  logic                      wr_en,
  input  logic [lbm_pkg::LIST_AW-1:0] wr_addr,
  input  lbm_pkg::list_rec_t        wr_rec
);
  import lbm_pkg::*;

  list_rec_t             mem [NUM_LISTS];
  logic [NUM_LISTS-1:0]  vld;
  list_rec_t             mem_q;
  logic                  vld_q;

  // Record memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Track written records; reset marks every list empty at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  // Unwritten records read as an empty list
  assign rd_rec = vld_q ? mem_q : REC_RESET;

endmodule

[rtl/core/multi_list_block_link_manager.sv]
// The block takes one item at a time: S_IDLE accepts the request beat and reads the record
//   and links into registers, S_EXEC modifies and loads the result register, and S_FIN does
//   the second link write-back; a stalled result holds the item in the modify step until it drains.
// Link tables are single-port-write memories, so each item writes them in two sets.
// Reset: synchronous; all lists read as empty at once (per-list valid bits),
//   link tables are not cleared and the block takes items right after reset.
module multi_list_block_link_manager (
  input logic       clk,
  input logic       rst,
  lbm_req_if.sink   req,
  lbm_rsp_if.source rsp
);
  import lbm_pkg::*;

  seq_state_t                state;
  seq_state_t                state_next;
  logic                      accept;
  logic                      advance;

  logic                      op_q;
  logic [LIST_IDX_W-1:0]     li_q;
  logic [BLOCK_IDX_W-1:0]    b_q;

  list_rec_t                 rec;
  list_rec_t                 rec_new;
  logic                      rec_wr;
  logic [LINK_W-1:0]         prev_rd;
  logic [LINK_W-1:0]         next_rd;

  link_wr_t                  w1_prev;
  link_wr_t                  w1_next;
  link_wr_t                  w2_prev;
  link_wr_t                  w2_next;
  link_wr_t                  pend_prev;
  link_wr_t                  pend_next;
  link_wr_t                  prev_wr;
  link_wr_t                  next_wr;

  logic                      res_status;
  list_rec_t                 res_rec;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    advance    = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !rst;
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        advance = !rsp.valid || rsp.ready;
        if (advance) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= req.opcode;
      li_q <= req.list_index;
      b_q  <= req.block_index;
    end
  end

  // Storage
  lbm_list_store u_list_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (LIST_AW'(req.list_index)),
    .rd_rec  (rec),
    .wr_en   (rec_wr),
    .wr_addr (LIST_AW'(li_q)),
    .wr_rec  (rec_new)
  );

  lbm_link_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(LINK_W)) u_prev_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (BLK_AW'(req.block_index)),
    .rd_data (prev_rd),
    .wr_en   (prev_wr.en),
    .wr_addr (prev_wr.addr[BLK_AW-1:0]),
    .wr_data (prev_wr.data)
  );

  lbm_link_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(LINK_W)) u_next_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (BLK_AW'(req.block_index)),
    .rd_data (next_rd),
    .wr_en   (next_wr.en),
    .wr_addr (next_wr.addr[BLK_AW-1:0]),
    .wr_data (next_wr.data)
  );

  // Modify: new list record and the two sets of link writes
  always_comb begin
    logic              li_ok;
    logic              b_ok;
    logic              empty;
    logic [LINK_W-1:0] b;
    li_ok      = int'(li_q) < NUM_LISTS;
    b_ok       = int'(b_q) < NUM_BLOCKS;
    b          = LINK_W'(b_q);
    empty      = (rec.head == NONE) && (rec.tail == NONE);
    rec_new    = rec;
    res_status = ST_DONE;
    w1_prev    = '0;
    w1_next    = '0;
    w2_prev    = '0;
    w2_next    = '0;
    if (op_q == OP_APPEND) begin
      // link the block behind the tail, then point the old tail at it
      rec_new.tail = b;
      rec_new.head = empty ? b : rec.head;
      w1_prev      = '{en: 1'b1, addr: b, data: empty ? NONE : rec.tail};
      w1_next      = '{en: 1'b1, addr: b, data: NONE};
      w2_next      = '{en: !empty, addr: rec.tail, data: b};
      if (int'(rec.count) < NUM_BLOCKS) begin
        rec_new.count = rec.count + 1'b1;
      end
    end else if (empty) begin
      res_status = ST_EMPTY;
    end else begin
      if (rec.head == rec.tail) begin
        rec_new.head = NONE;
        rec_new.tail = NONE;
        w2_prev      = '{en: 1'b1, addr: b, data: NONE};
        w2_next      = '{en: 1'b1, addr: b, data: NONE};
      end else if (b == rec.head && rec.count > 1) begin
        rec_new.head = next_rd;
        w1_prev      = '{en: 1'b1, addr: next_rd, data: NONE};
        w2_next      = '{en: 1'b1, addr: b, data: NONE};
      end else if (b == rec.tail && rec.count > 1) begin
        rec_new.tail = prev_rd;
        w1_next      = '{en: 1'b1, addr: prev_rd, data: NONE};
        w2_prev      = '{en: 1'b1, addr: b, data: NONE};
      end else begin
        // unlink from the middle; clear the block's own links last
        w1_next      = '{en: 1'b1, addr: prev_rd, data: next_rd};
        w1_prev      = '{en: 1'b1, addr: next_rd, data: prev_rd};
        w2_prev      = '{en: 1'b1, addr: b, data: NONE};
        w2_next      = '{en: 1'b1, addr: b, data: NONE};
      end
      if (rec.count != '0) begin
        rec_new.count = rec.count - 1'b1;
      end
    end
    // drop everything for an out-of-range list or block
    if (!li_ok || !b_ok) begin
      rec_new    = rec;
      res_status = ST_DONE;
      w1_prev    = '0;
      w1_next    = '0;
      w2_prev    = '0;
      w2_next    = '0;
    end
    rec_wr  = advance && li_ok && b_ok && !(op_q == OP_REMOVE && empty);
    res_rec = li_ok ? rec_new : REC_RESET;
  end

  // Hold the second write set for the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_prev.en <= 1'b0;
      pend_next.en <= 1'b0;
    end else begin
      pend_prev.en <= advance && w2_prev.en;
      pend_next.en <= advance && w2_next.en;
    end
    if (advance) begin
      pend_prev.addr <= w2_prev.addr;
      pend_prev.data <= w2_prev.data;
      pend_next.addr <= w2_next.addr;
      pend_next.data <= w2_next.data;
    end
  end

  // Drive the link write ports; drop writes at NONE or beyond
  always_comb begin
    prev_wr    = (state == S_FIN) ? pend_prev : w1_prev;
    next_wr    = (state == S_FIN) ? pend_next : w1_next;
    prev_wr.en = prev_wr.en && (int'(prev_wr.addr) < NUM_BLOCKS)
                 && (advance || state == S_FIN);
    next_wr.en = next_wr.en && (int'(next_wr.addr) < NUM_BLOCKS)
                 && (advance || state == S_FIN);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status      <= res_status;
      rsp.head_block  <= FIELD_W'(res_rec.head);
      rsp.tail_block  <= FIELD_W'(res_rec.tail);
      rsp.block_count <= FIELD_W'(res_rec.count);
    end
  end

endmodule

[rtl/core/lbm_checker.sv]
`include "multi_list_block_link_manager_assert.svh"

module lbm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_status,
  input logic [lbm_pkg::FIELD_W-1:0] rsp_head,
  input logic [lbm_pkg::FIELD_W-1:0] rsp_tail
);
  import lbm_pkg::*;

  // Reset empties the result register
  `LBM_ASSERT_NEXT_RAW(a_rst_clears_rsp, rst, !rsp_valid, "result valid after reset")

  // A result beat waits until taken
  `LBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")

  // One item at a time: no accept right after an accept
  `LBM_ASSERT_NEXT(a_req_spacing, req_valid && req_ready, !req_ready, "request taken too early")

  // An empty-list error reports an empty list
  `LBM_ASSERT_IMPL(a_err_empty, rsp_valid && rsp_status == ST_EMPTY,
    rsp_head == FIELD_W'(NONE) && rsp_tail == FIELD_W'(NONE), "error on non-empty list")

endmodule

bind multi_list_block_link_manager lbm_checker u_lbm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_head   (rsp.head_block),
  .rsp_tail   (rsp.tail_block)
);
